// ===== rtl/core/cpt_pkg.sv =====
// Shared constants, types and helpers of the closest-point-on-triangle unit.
`timescale 1ns / 1ps

package cpt_pkg;

  // Coordinate width and quotient precision.
  localparam int COORD_BITS = 16;
  localparam int QUOT_BITS  = 16;

  // Derived widths of the datapath.
  localparam int CW   = COORD_BITS;        // input coordinate
  localparam int DFW  = CW + 1;            // coordinate difference
  localparam int DPW  = 2 * DFW;           // one term of a dot product
  localparam int DW   = DPW + 2;           // dot product
  localparam int EDW  = DW + 1;            // difference of two dot products
  localparam int HW   = DW / 2;            // low half of a split dot product
  localparam int PPW  = 2 * HW + 2;        // partial product
  localparam int PW   = 2 * DW;            // cross product
  localparam int VW   = PW + 1;            // barycentric numerator
  localparam int NW   = VW + 2;            // quotient numerator and denominator
  localparam int QB   = QUOT_BITS;
  localparam int OW   = DFW + QB + 2;      // direction times quotient
  localparam int SW   = OW + 1;            // sum of two offsets
  localparam int FW   = SW - QB;           // offset on the coordinate grid
  localparam int EW   = CW + 1;            // distance component
  localparam int DSW  = 2 * CW + 2;        // squared distance
  localparam int SMW  = DSW + 2;           // sum of squares before masking

  localparam int CMAX = (1 <<< (CW - 1)) - 1;
  localparam int CMIN = -(1 <<< (CW - 1));

  // Queue between the front and back ends.
  localparam int QDEPTH = 16;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QLW    = QAW + 1;

  // Number of register stages in the front end.
  localparam int FST = 9;

  // Voronoi region codes.
  typedef enum logic [2:0] {
    REG_VERT_A  = 3'd0,
    REG_VERT_B  = 3'd1,
    REG_VERT_C  = 3'd2,
    REG_EDGE_AB = 3'd3,
    REG_EDGE_AC = 3'd4,
    REG_EDGE_BC = 3'd5,
    REG_FACE    = 3'd6
  } region_e;

  // Three-component vectors; element 0 is x.
  typedef logic [2:0][CW-1:0]  cvec_t;
  typedef logic [2:0][DFW-1:0] dvec_t;

  // Classified work item handed from the front end to the back end.
  typedef struct packed {
    region_e         region;
    logic            degen;
    cvec_t           p;
    cvec_t           base;
    dvec_t           dir1;
    dvec_t           dir2;
    logic [NW-1:0]   num1;
    logic [NW-1:0]   num2;
    logic [NW-1:0]   den;
    logic            zero1;
    logic            zero2;
  } job_t;

  // Signed difference of two coordinates.
  function automatic logic signed [DFW-1:0] sub_c(logic [CW-1:0] x, logic [CW-1:0] y);
    return DFW'($signed(x)) - DFW'($signed(y));
  endfunction

endpackage

// ===== rtl/core/cpt_front.sv =====
// Front end: dot products, cross terms, region classification and quotient setup.
`timescale 1ns / 1ps

module cpt_front import cpt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [CW-1:0]   point_x_i,
  input  logic [CW-1:0]   point_y_i,
  input  logic [CW-1:0]   point_z_i,
  input  logic [CW-1:0]   vert_a_x_i,
  input  logic [CW-1:0]   vert_a_y_i,
  input  logic [CW-1:0]   vert_a_z_i,
  input  logic [CW-1:0]   vert_b_x_i,
  input  logic [CW-1:0]   vert_b_y_i,
  input  logic [CW-1:0]   vert_b_z_i,
  input  logic [CW-1:0]   vert_c_x_i,
  input  logic [CW-1:0]   vert_c_y_i,
  input  logic [CW-1:0]   vert_c_z_i,
  input  logic [QLW-1:0]  q_level_i,
  output logic            push_o,
  output job_t            job_o
);

  typedef struct packed {
    cvec_t p;
    cvec_t a;
    cvec_t b;
    cvec_t c;
    dvec_t ab;
    dvec_t ac;
    dvec_t bc;
  } geo_t;

  typedef struct packed {
    region_e       region;
    logic          degen;
    cvec_t         p;
    cvec_t         base;
    dvec_t         dir1;
    dvec_t         dir2;
    logic [NW-1:0] num1;
    logic [NW-1:0] num2;
    logic [NW-1:0] den;
  } cls_t;

  // Operand pairs of the cross terms: d1*d4, d3*d2, d5*d2, d1*d6, d3*d6, d5*d4.
  localparam int PAIR_X [6] = '{0, 2, 4, 0, 2, 4};
  localparam int PAIR_Y [6] = '{3, 1, 1, 5, 5, 3};

  logic [FST-1:0]          v_q;
  logic [QLW:0]            credit_used;

  geo_t                    geo_q [1:7];
  geo_t                    geo2_d;
  dvec_t                   ap_d, bp_d, cp_d, ap_q, bp_q, cp_q;
  logic signed [DPW-1:0]   dp_d [6][3];
  logic signed [DPW-1:0]   dp_q [6][3];
  logic signed [DW-1:0]    d4_d [6];
  logic signed [DW-1:0]    d_q [4:7][6];
  logic signed [PPW-1:0]   ll_d [6], lh_d [6], hl_d [6], hh_d [6];
  logic signed [PPW-1:0]   ll_q [6], lh_q [6], hl_q [6], hh_q [6];
  logic signed [PW-1:0]    cr_d [6];
  logic signed [PW-1:0]    cr_q [6];
  logic signed [VW-1:0]    va_q, vb_q, vc_q;
  logic signed [EDW-1:0]   e43, e56;
  logic signed [NW-1:0]    face_den;
  cls_t                    cls_d, cls_q;
  job_t                    job_d, job_q;

  // An item is taken only when the queue has a slot for it and for all items in flight.
  assign credit_used = (QLW+1)'(q_level_i) + (QLW+1)'($countones(v_q));
  assign in_ready_o  = credit_used < (QLW+1)'(QDEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[FST-2:0], in_valid_i & in_ready_o};
    end
  end

  // Edge vectors and offsets of the point from each vertex.
  always_comb begin
    geo2_d = geo_q[1];
    for (int i = 0; i < 3; i++) begin
      geo2_d.ab[i] = sub_c(geo_q[1].b[i], geo_q[1].a[i]);
      geo2_d.ac[i] = sub_c(geo_q[1].c[i], geo_q[1].a[i]);
      geo2_d.bc[i] = sub_c(geo_q[1].c[i], geo_q[1].b[i]);
      ap_d[i]      = sub_c(geo_q[1].p[i], geo_q[1].a[i]);
      bp_d[i]      = sub_c(geo_q[1].p[i], geo_q[1].b[i]);
      cp_d[i]      = sub_c(geo_q[1].p[i], geo_q[1].c[i]);
    end
  end

  // Terms of the six dot products d1..d6.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dp_d[0][i] = $signed(geo_q[2].ab[i]) * $signed(ap_q[i]);
      dp_d[1][i] = $signed(geo_q[2].ac[i]) * $signed(ap_q[i]);
      dp_d[2][i] = $signed(geo_q[2].ab[i]) * $signed(bp_q[i]);
      dp_d[3][i] = $signed(geo_q[2].ac[i]) * $signed(bp_q[i]);
      dp_d[4][i] = $signed(geo_q[2].ab[i]) * $signed(cp_q[i]);
      dp_d[5][i] = $signed(geo_q[2].ac[i]) * $signed(cp_q[i]);
    end
  end

  // Dot product sums.
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      d4_d[j] = DW'(dp_q[j][0]) + DW'(dp_q[j][1]) + DW'(dp_q[j][2]);
    end
  end

  // Cross terms are split into half-width partial products.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      ll_d[k] = $signed({1'b0, d_q[4][PAIR_X[k]][HW-1:0]})
              * $signed({1'b0, d_q[4][PAIR_Y[k]][HW-1:0]});
      lh_d[k] = $signed({1'b0, d_q[4][PAIR_X[k]][HW-1:0]})
              * $signed(d_q[4][PAIR_Y[k]][DW-1:HW]);
      hl_d[k] = $signed(d_q[4][PAIR_X[k]][DW-1:HW])
              * $signed({1'b0, d_q[4][PAIR_Y[k]][HW-1:0]});
      hh_d[k] = $signed(d_q[4][PAIR_X[k]][DW-1:HW])
              * $signed(d_q[4][PAIR_Y[k]][DW-1:HW]);
    end
  end

  // Partial products are recombined into full cross terms.
  always_comb begin
    for (int k = 0; k < 6; k++) begin
      cr_d[k] = (PW'(hh_q[k]) <<< (2 * HW)) + ((PW'(lh_q[k]) + PW'(hl_q[k])) <<< HW)
              + PW'(ll_q[k]);
    end
  end

  // Region classification in priority order, with quotient operands per region.
  assign e43      = EDW'(d_q[7][3]) - EDW'(d_q[7][2]);
  assign e56      = EDW'(d_q[7][4]) - EDW'(d_q[7][5]);
  assign face_den = NW'(va_q) + NW'(vb_q) + NW'(vc_q);

  always_comb begin
    cls_d        = '0;
    cls_d.p      = geo_q[7].p;
    cls_d.region = REG_FACE;
    priority if (d_q[7][0] <= 0 && d_q[7][1] <= 0) begin
      cls_d.region = REG_VERT_A;
      cls_d.base   = geo_q[7].a;
    end else if (d_q[7][2] >= 0 && d_q[7][3] <= d_q[7][2]) begin
      cls_d.region = REG_VERT_B;
      cls_d.base   = geo_q[7].b;
    end else if (d_q[7][5] >= 0 && d_q[7][4] <= d_q[7][5]) begin
      cls_d.region = REG_VERT_C;
      cls_d.base   = geo_q[7].c;
    end else if (vc_q <= 0 && d_q[7][0] >= 0 && d_q[7][2] <= 0) begin
      cls_d.region = REG_EDGE_AB;
      cls_d.base   = geo_q[7].a;
      cls_d.dir1   = geo_q[7].ab;
      cls_d.num1   = NW'(d_q[7][0]);
      cls_d.den    = NW'(d_q[7][0]) - NW'(d_q[7][2]);
    end else if (vb_q <= 0 && d_q[7][1] >= 0 && d_q[7][5] <= 0) begin
      cls_d.region = REG_EDGE_AC;
      cls_d.base   = geo_q[7].a;
      cls_d.dir1   = geo_q[7].ac;
      cls_d.num1   = NW'(d_q[7][1]);
      cls_d.den    = NW'(d_q[7][1]) - NW'(d_q[7][5]);
    end else if (va_q <= 0 && e43 >= 0 && e56 >= 0) begin
      cls_d.region = REG_EDGE_BC;
      cls_d.base   = geo_q[7].b;
      cls_d.dir1   = geo_q[7].bc;
      cls_d.num1   = NW'(e43);
      cls_d.den    = NW'(e43) + NW'(e56);
    end else begin
      cls_d.region = REG_FACE;
      cls_d.base   = geo_q[7].a;
      cls_d.dir1   = geo_q[7].ab;
      cls_d.dir2   = geo_q[7].ac;
      cls_d.num1   = NW'(vb_q);
      cls_d.num2   = NW'(vc_q);
      cls_d.den    = face_den;
      cls_d.degen  = (face_den == '0);
    end
  end

  // Magnitudes for the divider; a quotient is zero when signs differ or an operand is zero.
  always_comb begin
    job_d.region = cls_q.region;
    job_d.degen  = cls_q.degen;
    job_d.p      = cls_q.p;
    job_d.base   = cls_q.base;
    job_d.dir1   = cls_q.dir1;
    job_d.dir2   = cls_q.dir2;
    job_d.num1   = cls_q.num1[NW-1] ? NW'(-$signed(cls_q.num1)) : cls_q.num1;
    job_d.num2   = cls_q.num2[NW-1] ? NW'(-$signed(cls_q.num2)) : cls_q.num2;
    job_d.den    = cls_q.den[NW-1] ? NW'(-$signed(cls_q.den)) : cls_q.den;
    job_d.zero1  = (cls_q.num1 == '0) || (cls_q.den == '0)
                || (cls_q.num1[NW-1] != cls_q.den[NW-1]);
    job_d.zero2  = (cls_q.num2 == '0) || (cls_q.den == '0)
                || (cls_q.num2[NW-1] != cls_q.den[NW-1]);
  end

  // Datapath registers advance every cycle; the valid bits mark live items.
  always_ff @(posedge clk_i) begin
    geo_q[1].p  <= {point_z_i, point_y_i, point_x_i};
    geo_q[1].a  <= {vert_a_z_i, vert_a_y_i, vert_a_x_i};
    geo_q[1].b  <= {vert_b_z_i, vert_b_y_i, vert_b_x_i};
    geo_q[1].c  <= {vert_c_z_i, vert_c_y_i, vert_c_x_i};
    geo_q[1].ab <= '0;
    geo_q[1].ac <= '0;
    geo_q[1].bc <= '0;
    geo_q[2]    <= geo2_d;
    for (int k = 3; k <= 7; k++) begin
      geo_q[k] <= geo_q[k-1];
    end
    ap_q    <= ap_d;
    bp_q    <= bp_d;
    cp_q    <= cp_d;
    dp_q    <= dp_d;
    d_q[4]  <= d4_d;
    for (int k = 5; k <= 7; k++) begin
      d_q[k] <= d_q[k-1];
    end
    ll_q    <= ll_d;
    lh_q    <= lh_d;
    hl_q    <= hl_d;
    hh_q    <= hh_d;
    cr_q    <= cr_d;
    vc_q    <= VW'(cr_q[0]) - VW'(cr_q[1]);
    vb_q    <= VW'(cr_q[2]) - VW'(cr_q[3]);
    va_q    <= VW'(cr_q[4]) - VW'(cr_q[5]);
    cls_q   <= cls_d;
    job_q   <= job_d;
  end

  assign push_o = v_q[FST-1];
  assign job_o  = job_q;

  // A pushed item always finds room: credits were reserved at acceptance.
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> q_level_i < QLW'(QDEPTH))
    else $error("front end pushed into a full queue");

  // Vertex regions carry no quotient.
  a_vertex_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && (job_q.region == REG_VERT_A || job_q.region == REG_VERT_B
            || job_q.region == REG_VERT_C) |-> job_q.zero1 && job_q.zero2)
    else $error("vertex region with nonzero quotient");

endmodule

// ===== rtl/core/cpt_queue.sv =====
// Work queue between the front end and the back end.
`timescale 1ns / 1ps

module cpt_queue import cpt_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  job_t            job_i,
  input  logic            pop_i,
  output job_t            job_o,
  output logic            not_empty_o,
  output logic [QLW-1:0]  level_o
);

  job_t            mem_q [QDEPTH];
  logic [QAW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QLW-1:0]  count_q;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + QAW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QLW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QLW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o       = mem_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign level_o     = count_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q != QLW'(QDEPTH))
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("queue underflow");

endmodule

// ===== rtl/core/cpt_back.sv =====
// Back end: pipelined quotient, point placement, squared distance and output register.
`timescale 1ns / 1ps

module cpt_back import cpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  job_t              q_job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DSW-1:0]    dist_sq_o,
  output logic [CW-1:0]     near_x_o,
  output logic [CW-1:0]     near_y_o,
  output logic [CW-1:0]     near_z_o,
  output logic [2:0]        region_o,
  output logic              degenerate_o
);

  typedef struct packed {
    job_t            job;
    logic [NW-1:0]   rem1;
    logic [NW-1:0]   rem2;
    logic [QB-1:0]   q1;
    logic [QB-1:0]   q2;
    logic            skip1;
    logic            skip2;
    logic            sat1;
    logic            sat2;
  } div_t;

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [QB-1:0] q;
  } dstep_t;

  typedef struct packed {
    region_e region;
    logic    degen;
    cvec_t   p;
    cvec_t   pos;
  } tail_t;

  logic                   back_en;
  logic                   j_v_q;
  job_t                   j_q;
  logic [QB:0]            dv_q;
  div_t                   ds_d [QB+1];
  div_t                   ds_q [QB+1];
  logic [QB:0]            t1, t2;
  logic                   pl_v_q, ps_v_q, sq_v_q, out_valid_q;
  tail_t                  pl_tail_d, pl_tail_q, ps_tail_d, ps_tail_q, sq_tail_q;
  logic signed [OW-1:0]   off1_d [3], off2_d [3], off1_q [3], off2_q [3];
  logic signed [SW-1:0]   sum_s [3];
  logic signed [FW:0]     pos_s [3];
  logic signed [EW-1:0]   diff_s [3];
  logic [2*EW-1:0]        dd_d [3], dd_q [3];
  logic [SMW-1:0]         dist_s;
  logic [DSW-1:0]         dist_q;
  cvec_t                  near_q;
  region_e                region_q;
  logic                   degen_q;

  // One restoring division step, held when the quotient is already settled.
  function automatic dstep_t div_step(logic [NW-1:0] rem, logic [QB-1:0] q,
                                      logic [NW-1:0] den, logic hold);
    logic [NW:0] tr;
    dstep_t      r;
    tr    = {rem, 1'b0};
    r.rem = rem;
    r.q   = q;
    if (!hold) begin
      if (tr >= {1'b0, den}) begin
        r.rem = NW'(tr - {1'b0, den});
        r.q   = {q[QB-2:0], 1'b1};
      end else begin
        r.rem = tr[NW-1:0];
        r.q   = {q[QB-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // Final quotient in [0, 1] with QB fraction bits.
  function automatic logic [QB:0] quot_val(logic skip, logic sat, logic [QB-1:0] q);
    logic [QB:0] r;
    if (skip) begin
      r = '0;
    end else if (sat) begin
      r = {1'b1, {QB{1'b0}}};
    end else begin
      r = {1'b0, q};
    end
    return r;
  endfunction

  // The whole back end moves when the output register is free or being emptied.
  assign back_en = !out_valid_q || out_ready_i;
  assign pop_o   = back_en && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      j_v_q       <= 1'b0;
      dv_q        <= '0;
      pl_v_q      <= 1'b0;
      ps_v_q      <= 1'b0;
      sq_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (back_en) begin
      j_v_q       <= pop_o;
      dv_q        <= {dv_q[QB-1:0], j_v_q};
      pl_v_q      <= dv_q[QB];
      ps_v_q      <= pl_v_q;
      sq_v_q      <= ps_v_q;
      out_valid_q <= sq_v_q;
    end
  end

  // Divider setup, then one quotient bit per stage for both lanes.
  always_comb begin
    ds_d[0].job   = j_q;
    ds_d[0].rem1  = j_q.num1;
    ds_d[0].rem2  = j_q.num2;
    ds_d[0].q1    = '0;
    ds_d[0].q2    = '0;
    ds_d[0].skip1 = j_q.zero1;
    ds_d[0].skip2 = j_q.zero2;
    ds_d[0].sat1  = (j_q.num1 >= j_q.den);
    ds_d[0].sat2  = (j_q.num2 >= j_q.den);
    for (int k = 0; k < QB; k++) begin
      ds_d[k+1] = ds_q[k];
      {ds_d[k+1].rem1, ds_d[k+1].q1} = div_step(ds_q[k].rem1, ds_q[k].q1, ds_q[k].job.den,
                                                ds_q[k].skip1 || ds_q[k].sat1);
      {ds_d[k+1].rem2, ds_d[k+1].q2} = div_step(ds_q[k].rem2, ds_q[k].q2, ds_q[k].job.den,
                                                ds_q[k].skip2 || ds_q[k].sat2);
    end
  end

  // Offsets along the edge directions.
  assign t1 = quot_val(ds_q[QB].skip1, ds_q[QB].sat1, ds_q[QB].q1);
  assign t2 = quot_val(ds_q[QB].skip2, ds_q[QB].sat2, ds_q[QB].q2);

  always_comb begin
    pl_tail_d.region = ds_q[QB].job.region;
    pl_tail_d.degen  = ds_q[QB].job.degen;
    pl_tail_d.p      = ds_q[QB].job.p;
    pl_tail_d.pos    = ds_q[QB].job.base;
    for (int i = 0; i < 3; i++) begin
      off1_d[i] = $signed(ds_q[QB].job.dir1[i]) * $signed({1'b0, t1});
      off2_d[i] = $signed(ds_q[QB].job.dir2[i]) * $signed({1'b0, t2});
    end
  end

  // Offset rounded toward minus infinity, added to the base and saturated.
  always_comb begin
    ps_tail_d = pl_tail_q;
    for (int i = 0; i < 3; i++) begin
      sum_s[i] = SW'(off1_q[i]) + SW'(off2_q[i]);
      pos_s[i] = (FW+1)'($signed(pl_tail_q.pos[i])) + (FW+1)'($signed(sum_s[i][SW-1:QB]));
      if (pos_s[i] > (FW+1)'(CMAX)) begin
        ps_tail_d.pos[i] = CW'(CMAX);
      end else if (pos_s[i] < (FW+1)'(CMIN)) begin
        ps_tail_d.pos[i] = CW'(CMIN);
      end else begin
        ps_tail_d.pos[i] = pos_s[i][CW-1:0];
      end
    end
  end

  // Squared components of the distance.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_s[i] = EW'($signed(ps_tail_q.p[i])) - EW'($signed(ps_tail_q.pos[i]));
      dd_d[i]   = (2*EW)'(diff_s[i] * diff_s[i]);
    end
  end

  assign dist_s = SMW'(dd_q[0]) + SMW'(dd_q[1]) + SMW'(dd_q[2]);

  always_ff @(posedge clk_i) begin
    if (back_en) begin
      j_q <= q_job_i;
      for (int k = 0; k <= QB; k++) begin
        ds_q[k] <= ds_d[k];
      end
      pl_tail_q <= pl_tail_d;
      off1_q    <= off1_d;
      off2_q    <= off2_d;
      ps_tail_q <= ps_tail_d;
      sq_tail_q <= ps_tail_q;
      dd_q      <= dd_d;
      dist_q    <= dist_s[DSW-1:0];
      near_q    <= sq_tail_q.pos;
      region_q  <= sq_tail_q.region;
      degen_q   <= sq_tail_q.degen;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign dist_sq_o    = dist_q;
  assign near_x_o     = near_q[0];
  assign near_y_o     = near_q[1];
  assign near_z_o     = near_q[2];
  assign region_o     = region_q;
  assign degenerate_o = degen_q;

  // A degenerate face has a zero denominator, so both quotients are forced to zero.
  a_degen_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_q[QB] && ds_q[QB].job.degen |-> ds_q[QB].skip1 && ds_q[QB].skip2)
    else $error("degenerate face with live quotient");

  // Only the interior region can be degenerate.
  a_degen_face: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && degenerate_o |-> region_o == REG_FACE)
    else $error("degenerate flag outside the interior region");

endmodule

// ===== rtl/core/closest_point_on_triangle_unit.sv =====
// Top level of the closest-point-on-triangle unit.
//
// Channel  Dir  Handshake                   Transaction contents
// in       in   in_valid_i / in_ready_o     query point, vertices a, b and c
// out      out  out_valid_o / out_ready_i   dist_sq, near point, region, degenerate
//
// One transaction is taken per cycle in steady state while in_ready_o stays high; an
// accepted transaction passes the front end's nine stages (dot and cross products), the
// queue write, the back end's input register, the divider setup and its sixteen
// stages of one quotient bit each, and four placement and distance stages before
// out_valid_o rises for it.
// A 16-entry queue separates the two ends; input is taken while the queue has room for
// the new item and every item still in the front end.
// An output stall holds the back end while the front end keeps filling the queue.
// Reset is asynchronous and active low; it empties every stage and the queue.
`timescale 1ns / 1ps

module closest_point_on_triangle_unit import cpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [CW-1:0]     point_x_i,
  input  logic [CW-1:0]     point_y_i,
  input  logic [CW-1:0]     point_z_i,
  input  logic [CW-1:0]     vert_a_x_i,
  input  logic [CW-1:0]     vert_a_y_i,
  input  logic [CW-1:0]     vert_a_z_i,
  input  logic [CW-1:0]     vert_b_x_i,
  input  logic [CW-1:0]     vert_b_y_i,
  input  logic [CW-1:0]     vert_b_z_i,
  input  logic [CW-1:0]     vert_c_x_i,
  input  logic [CW-1:0]     vert_c_y_i,
  input  logic [CW-1:0]     vert_c_z_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DSW-1:0]    dist_sq_o,
  output logic [CW-1:0]     near_x_o,
  output logic [CW-1:0]     near_y_o,
  output logic [CW-1:0]     near_z_o,
  output logic [2:0]        region_o,
  output logic              degenerate_o
);

  logic            push;
  logic            pop;
  logic            q_not_empty;
  logic [QLW-1:0]  q_level;
  job_t            push_job;
  job_t            head_job;

  // Classification front end.
  cpt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .point_x_i  (point_x_i),
    .point_y_i  (point_y_i),
    .point_z_i  (point_z_i),
    .vert_a_x_i (vert_a_x_i),
    .vert_a_y_i (vert_a_y_i),
    .vert_a_z_i (vert_a_z_i),
    .vert_b_x_i (vert_b_x_i),
    .vert_b_y_i (vert_b_y_i),
    .vert_b_z_i (vert_b_z_i),
    .vert_c_x_i (vert_c_x_i),
    .vert_c_y_i (vert_c_y_i),
    .vert_c_z_i (vert_c_z_i),
    .q_level_i  (q_level),
    .push_o     (push),
    .job_o      (push_job)
  );

  // Decoupling queue.
  cpt_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .job_i       (push_job),
    .pop_i       (pop),
    .job_o       (head_job),
    .not_empty_o (q_not_empty),
    .level_o     (q_level)
  );

  // Division, placement and distance back end.
  cpt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_not_empty),
    .q_job_i      (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .dist_sq_o    (dist_sq_o),
    .near_x_o     (near_x_o),
    .near_y_o     (near_y_o),
    .near_z_o     (near_z_o),
    .region_o     (region_o),
    .degenerate_o (degenerate_o)
  );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench of the closest-point-on-triangle unit with a scoreboard class.
`timescale 1ns / 1ps

module tb_top;
  import cpt_pkg::*;

  typedef logic signed [127:0] wide_t;
  typedef logic [CW-1:0] query_t [12];

  // Expected result of one query.
  typedef struct {
    logic [DSW-1:0] dsq;
    logic [CW-1:0]  nx, ny, nz;
    region_e        region;
    logic           degen;
  } nearest_t;

  // Keeps the nearest points owed by the unit and compares what comes out.
  class nearest_scoreboard;
    nearest_t owed[$];
    int       errors;

    // Quotient truncated to QB fraction bits and clamped to [0,1].
    function automatic longint ratio(wide_t num, wide_t den);
      wide_t  r;
      longint q;
      q = 0;
      if (den == 0 || num == 0 || num[127] != den[127]) return 0;
      if (num[127]) begin
        num = -num;
        den = -den;
      end
      if (num >= den) return longint'(1) << QB;
      r = num;
      for (int i = 0; i < QB; i++) begin
        r = r <<< 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
      return q;
    endfunction

    // Base plus the floored offset, saturated to the coordinate range.
    function automatic longint shift_point(longint base, longint d1, longint t1,
                                           longint d2, longint t2);
      longint v;
      v = base + ((d1 * t1 + d2 * t2) >>> QB);
      if (v > CMAX) v = CMAX;
      if (v < CMIN) v = CMIN;
      return v;
    endfunction

    function automatic nearest_t nearest(query_t q);
      longint   p[3], a[3], b[3], c[3], ab[3], ac[3], bc[3], e[3];
      longint   d1, d2, d3, d4, d5, d6, t, v, u, df;
      wide_t    va, vb, vc, den;
      nearest_t r;
      logic [63:0] acc;
      for (int i = 0; i < 3; i++) begin
        p[i] = longint'($signed(q[i]));
        a[i] = longint'($signed(q[3+i]));
        b[i] = longint'($signed(q[6+i]));
        c[i] = longint'($signed(q[9+i]));
        ab[i] = b[i] - a[i];
        ac[i] = c[i] - a[i];
        bc[i] = c[i] - b[i];
      end
      d1 = 0; d2 = 0; d3 = 0; d4 = 0; d5 = 0; d6 = 0;
      for (int i = 0; i < 3; i++) begin
        d1 += ab[i] * (p[i] - a[i]);
        d2 += ac[i] * (p[i] - a[i]);
        d3 += ab[i] * (p[i] - b[i]);
        d4 += ac[i] * (p[i] - b[i]);
        d5 += ab[i] * (p[i] - c[i]);
        d6 += ac[i] * (p[i] - c[i]);
      end
      vc = wide_t'(d1) * wide_t'(d4) - wide_t'(d3) * wide_t'(d2);
      vb = wide_t'(d5) * wide_t'(d2) - wide_t'(d1) * wide_t'(d6);
      va = wide_t'(d3) * wide_t'(d6) - wide_t'(d5) * wide_t'(d4);
      r.degen = 1'b0;
      if (d1 <= 0 && d2 <= 0) begin
        r.region = REG_VERT_A;
        e = a;
      end else if (d3 >= 0 && d4 <= d3) begin
        r.region = REG_VERT_B;
        e = b;
      end else if (d6 >= 0 && d5 <= d6) begin
        r.region = REG_VERT_C;
        e = c;
      end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
        r.region = REG_EDGE_AB;
        t = ratio(wide_t'(d1), wide_t'(d1 - d3));
        for (int i = 0; i < 3; i++) e[i] = shift_point(a[i], ab[i], t, 0, 0);
      end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
        r.region = REG_EDGE_AC;
        t = ratio(wide_t'(d2), wide_t'(d2 - d6));
        for (int i = 0; i < 3; i++) e[i] = shift_point(a[i], ac[i], t, 0, 0);
      end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
        r.region = REG_EDGE_BC;
        t = ratio(wide_t'(d4 - d3), wide_t'((d4 - d3) + (d5 - d6)));
        for (int i = 0; i < 3; i++) e[i] = shift_point(b[i], bc[i], t, 0, 0);
      end else begin
        r.region = REG_FACE;
        den = va + vb + vc;
        if (den == 0) begin
          r.degen = 1'b1;
          e = a;
        end else begin
          v = ratio(vb, den);
          u = ratio(vc, den);
          for (int i = 0; i < 3; i++) e[i] = shift_point(a[i], ab[i], v, ac[i], u);
        end
      end
      acc = 0;
      for (int i = 0; i < 3; i++) begin
        df = p[i] - e[i];
        acc += 64'(df * df);
      end
      r.dsq = acc[DSW-1:0];
      r.nx = e[0][CW-1:0];
      r.ny = e[1][CW-1:0];
      r.nz = e[2][CW-1:0];
      return r;
    endfunction

    function void note_query(query_t q);
      owed.push_back(nearest(q));
    endfunction

    function void check_result(logic [DSW-1:0] dsq, logic [CW-1:0] nx, logic [CW-1:0] ny,
                               logic [CW-1:0] nz, logic [2:0] region, logic degen);
      nearest_t x;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: dist_sq %0h region %0d", dsq, region);
        return;
      end
      x = owed.pop_front();
      if (dsq !== x.dsq || nx !== x.nx || ny !== x.ny || nz !== x.nz ||
          region !== x.region || degen !== x.degen) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp d=%0h (%0h,%0h,%0h) r=%0d g=%0b  %s",
                   x.dsq, x.nx, x.ny, x.nz, x.region, x.degen,
                   $sformatf("got d=%0h (%0h,%0h,%0h) r=%0d g=%0b",
                             dsq, nx, ny, nz, region, degen));
      end
    endfunction
  endclass

  logic           clk_i, rst_ni;
  logic           in_valid = 1'b0;
  logic           in_ready, out_valid;
  logic           out_ready = 1'b0;
  logic [CW-1:0]  drv [12] = '{default: '0};
  logic [DSW-1:0] dist_sq;
  logic [CW-1:0]  near_x, near_y, near_z;
  logic [2:0]     region;
  logic           degenerate;

  nearest_scoreboard sb;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_len = 0;
  int hold_cnt = 0;
  bit hold_taken = 1'b0;

  closest_point_on_triangle_unit dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .point_x_i(drv[0]), .point_y_i(drv[1]), .point_z_i(drv[2]),
    .vert_a_x_i(drv[3]), .vert_a_y_i(drv[4]), .vert_a_z_i(drv[5]),
    .vert_b_x_i(drv[6]), .vert_b_y_i(drv[7]), .vert_b_z_i(drv[8]),
    .vert_c_x_i(drv[9]), .vert_c_y_i(drv[10]), .vert_c_z_i(drv[11]),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .dist_sq_o(dist_sq), .near_x_o(near_x), .near_y_o(near_y), .near_z_o(near_z),
    .region_o(region), .degenerate_o(degenerate)
  );

  // Clock and reset.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    sb = new();
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Receiver: random stalls, plus one long hold-off counted here once it is asked for.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else if (hold_len != 0 && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_cnt   <= hold_len - 1;
      out_ready  <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Monitors of both channels.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && in_ready) sb.note_query(drv);
    if (rst_ni && out_valid && out_ready)
      sb.check_result(dist_sq, near_x, near_y, near_z, region, degenerate);
  end

  // Offers one query and returns at the edge that accepts it.
  task automatic send_query(query_t q);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 12; i++) drv[i] <= q[i];
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic send_coords(int px, int py, int pz, int ax, int ay, int az,
                             int bx, int by, int bz, int cx, int cy, int cz);
    query_t q;
    q = '{px[15:0], py[15:0], pz[15:0], ax[15:0], ay[15:0], az[15:0],
          bx[15:0], by[15:0], bz[15:0], cx[15:0], cy[15:0], cz[15:0]};
    send_query(q);
  endtask

  // Random query: mostly compact triangles with a nearby point, some full range.
  function automatic query_t random_query();
    query_t q;
    int     mode, span, ctr[3], dir[3];
    mode = $urandom_range(99);
    span = 1 << $urandom_range(12, 1);
    for (int k = 0; k < 3; k++) begin
      ctr[k] = $urandom_range(65535) - 32768;
      dir[k] = $urandom_range(2 * span) - span;
    end
    for (int i = 0; i < 12; i++) begin
      if (mode < 15) q[i] = 16'($urandom_range(65535));
      else q[i] = 16'(ctr[i % 3] + $urandom_range(2 * span) - span);
    end
    if (mode >= 15 && mode < 25) begin
      // Vertex b is copied from vertex a or from itself, so two vertices may coincide.
      for (int k = 0; k < 3; k++) q[6 + k] = q[3 + 3 * $urandom_range(2, 1) - 3 + k];
    end else if (mode >= 25 && mode < 35) begin
      // Collinear vertices.
      for (int k = 0; k < 3; k++) begin
        q[6 + k] = 16'(int'($signed(q[3 + k])) + dir[k]);
        q[9 + k] = 16'(int'($signed(q[3 + k])) + dir[k] * ($urandom_range(4) - 2));
      end
    end else if (mode >= 35 && mode < 40) begin
      // Extreme coordinates.
      for (int i = 0; i < 12; i++)
        q[i] = $urandom_range(1) ? 16'h7fff : 16'h8000;
    end
    return q;
  endfunction

  task automatic wait_drained();
    while (sb.owed.size() != 0) @(posedge clk_i);
  endtask

  // Stimulus and end of run.
  initial begin
    int phase_idle[4], phase_stall[4];
    phase_idle  = '{0, 76, 0, 29};
    phase_stall = '{0, 0, 76, 29};
    @(posedge rst_ni);
    @(posedge clk_i);
    // Directed: every region, extremes, coincident and collinear vertices.
    send_coords(-10, -10, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    send_coords(300, -5, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    send_coords(-5, 300, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    send_coords(100, -50, 7, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    send_coords(-50, 100, -7, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    send_coords(200, 200, 3, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    send_coords(60, 70, 90, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    send_coords(60, 70, -90, 0, 0, 0, 256, 0, 0, 0, 256, 0);
    send_coords(5, 5, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_coords(3, 1, 0, 0, 0, 0, 4, 0, 0, 2, 0, 0);
    send_coords(3, 5, 0, 0, 0, 0, 2, 0, 0, 4, 0, 0);
    send_coords(1, 9, 0, 2, 0, 0, 0, 0, 0, 4, 0, 0);
    send_coords(50, 50, 0, 0, 0, 0, 0, 0, 0, 100, 0, 0);
    send_coords(32767, 32767, 32767, -32768, -32768, -32768, 32767, -32768, -32768,
                -32768, 32767, -32768);
    send_coords(-32768, -32768, -32768, 32767, 32767, 32767, -32768, 32767, 32767,
                32767, -32768, 32767);
    send_coords(0, 0, 32767, -32768, -32768, 0, 32767, -32768, 0, 0, 32767, 0);
    send_coords(32767, -32768, 0, 32767, 32767, 32767, 32767, 32767, 32767,
                -32768, -32768, -32768);
    send_coords(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
    send_coords(1, 2, 3, 10, 3, -4, 7, 8, -9, -2, 11, 5);
    // Random phases with different idle and stall mixes.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = phase_idle[ph];
      stall_pct = phase_stall[ph];
      for (int n = 0; n < 430; n++) send_query(random_query());
    end
    // Long receiver hold-off while the sender keeps offering, then a full drain.
    send_idle_pct = 0;
    stall_pct = 0;
    hold_len = 200;
    for (int n = 0; n < 120; n++) send_query(random_query());
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    for (int n = 0; n < 100; n++) send_query(random_query());
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait_drained();
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.owed.size() == 0) begin
      $display("[closest_point_on_triangle_unit] OK");
    end else begin
      $display("[closest_point_on_triangle_unit] ERROR");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #5ms;
    $display("[closest_point_on_triangle_unit] ERROR");
    $finish;
  end

endmodule
